// ===== sv/b64d_pkg.sv =====
// Package for the base64 stream decoder: item types, character codes,
// the alphabet lookup and the work-queue sizing. No dependencies.
package b64d_pkg;

  localparam logic [6:0] SYM_INVALID = 7'd127;
  localparam logic [6:0] SYM_PAD     = 7'd64;

  localparam logic [7:0] CHAR_PAD = 8'h3D;
  localparam logic [7:0] CHAR_CR  = 8'h0D;
  localparam logic [7:0] CHAR_LF  = 8'h0A;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  // Work queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] in_char;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       kind;
    logic       status;
    logic       last_result;
  } out_item_t;

  // One finished group's worth of results: up to three bytes plus an
  // optional end-of-stream status.
  typedef struct packed {
    logic [23:0] data;
    logic [1:0]  nbytes;
    logic        is_end;
    logic        status;
  } work_t;

  function automatic logic [6:0] sym_value(input logic [7:0] c);
    logic [6:0] v;
    v = SYM_INVALID;
    if (c >= 8'h41 && c <= 8'h5A) v = 7'(c - 8'h41);
    else if (c >= 8'h61 && c <= 8'h7A) v = 7'(c - 8'h61 + 8'd26);
    else if (c >= 8'h30 && c <= 8'h39) v = 7'(c - 8'h30 + 8'd52);
    else if (c == 8'h2B) v = 7'd62;
    else if (c == 8'h2F) v = 7'd63;
    else if (c == CHAR_PAD) v = SYM_PAD;
    return v;
  endfunction

endpackage

// ===== sv/base64_stream_decoder_core.sv =====
// Top level of the streaming base64 decoder: front, work queue and back.
// Depends on b64d_pkg, b64d_front, b64d_fifo and b64d_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------
//   input    | in_push / in_full      | in_item : in_char, last_char
//   result   | out_pop / out_empty    | out_item: out_byte, kind, status,
//            |                        |           last_result
//
// One character is taken per cycle whenever the four-entry work queue has
// room; the front decodes it in the same cycle and queues a work item at
// each group or stream end. The back hands out one result per cycle while
// out_pop is high (up to four per item), which bounds the character rate.
// Reset (rst_n low, synchronous) clears decoder state, queue and back.
// A stalled result side fills the queue, which then raises in_full.
module base64_stream_decoder_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  b64d_pkg::in_item_t  in_item,
  output logic                in_full,
  input  logic                out_pop,
  output logic                out_empty,
  output b64d_pkg::out_item_t out_item
);

  logic            q_full;
  logic            q_push;
  b64d_pkg::work_t q_wr_item;
  logic            q_pop;
  logic            q_empty;
  b64d_pkg::work_t q_rd_item;

  // Decode characters and track group, pad, CR and error state.
  b64d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_item  (q_wr_item)
  );

  // Hold finished groups and end markers until the back takes them.
  b64d_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .rd_item (q_rd_item),
    .empty   (q_empty)
  );

  // Serialize each work item into byte and status results.
  b64d_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_item    (q_rd_item),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

// ===== sv/b64d_front.sv =====
// Front of the base64 decoder: accepts characters, tracks group and line
// state, and pushes finished groups and end markers as work items.
// Depends on b64d_pkg.
module b64d_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  b64d_pkg::in_item_t in_item,
  output logic               in_full,
  input  logic               q_full,
  output logic               q_push,
  output b64d_pkg::work_t    q_item
);

  logic [1:0]  pos_r, pos_nxt;
  logic [23:0] acc_r, acc_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        crp_r, crp_nxt;
  logic        err_r, err_nxt;

  logic        accept;
  logic        skip;
  logic [6:0]  sym;
  logic [1:0]  pad;
  logic [1:0]  nbytes;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign sym     = b64d_pkg::sym_value(in_item.in_char);

  always_comb begin
    pos_nxt = pos_r;
    acc_nxt = acc_r;
    pad_nxt = pad_r;
    crp_nxt = crp_r;
    err_nxt = err_r;
    skip    = 1'b0;
    pad     = pad_r;
    nbytes  = 2'd0;
    if (!err_r) begin
      // resolve a pending CR first
      if (crp_r) begin
        crp_nxt = 1'b0;
        if (in_item.in_char == b64d_pkg::CHAR_LF) skip = 1'b1;
        else err_nxt = 1'b1;
      end
      if (!err_nxt && !skip) begin
        if (in_item.in_char == b64d_pkg::CHAR_CR) begin
          if (in_item.last_char) err_nxt = 1'b1;
          else crp_nxt = 1'b1;
        end else if (in_item.in_char != b64d_pkg::CHAR_LF) begin
          if (sym == b64d_pkg::SYM_PAD) begin
            if (pad_r >= 2'd2) err_nxt = 1'b1;
            else pad = pad_r + 2'd1;
          end
          if (!err_nxt) begin
            if (sym == b64d_pkg::SYM_INVALID) err_nxt = 1'b1;
            else if (sym < b64d_pkg::SYM_PAD && pad != 2'd0) err_nxt = 1'b1;
          end
          pad_nxt = pad;
          if (!err_nxt) begin
            acc_nxt = {acc_r[17:0], sym[5:0]};
            pos_nxt = pos_r + 2'd1;
            if (pos_nxt == 2'd0) nbytes = 2'd3 - pad;
          end
        end
      end
    end
  end

  always_comb begin
    q_item.data   = acc_nxt;
    q_item.nbytes = nbytes;
    q_item.is_end = in_item.last_char;
    q_item.status = err_nxt ? b64d_pkg::STATUS_INVALID : b64d_pkg::STATUS_OK;
  end

  // characters that cause no result never enter the queue
  assign q_push = accept && (nbytes != 2'd0 || in_item.last_char);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      acc_r <= '0;
      pad_r <= '0;
      crp_r <= 1'b0;
      err_r <= 1'b0;
    end else if (accept) begin
      if (in_item.last_char) begin
        pos_r <= '0;
        acc_r <= '0;
        pad_r <= '0;
        crp_r <= 1'b0;
        err_r <= 1'b0;
      end else begin
        pos_r <= pos_nxt;
        acc_r <= acc_nxt;
        pad_r <= pad_nxt;
        crp_r <= crp_nxt;
        err_r <= err_nxt;
      end
    end
  end

endmodule

// ===== sv/b64d_fifo.sv =====
// Work queue between the decoder front and back: a small circular buffer
// of work items. Depends on b64d_pkg.
module b64d_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64d_pkg::work_t wr_item,
  output logic            full,
  input  logic            pop,
  output b64d_pkg::work_t rd_item,
  output logic            empty
);

  b64d_pkg::work_t mem [b64d_pkg::QDEPTH];

  logic [b64d_pkg::QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [b64d_pkg::QAW:0]   count_r, count_nxt;
  logic                     do_push, do_pop;

  assign full    = count_r == (b64d_pkg::QAW+1)'(b64d_pkg::QDEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_item = mem[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

endmodule

// ===== sv/b64d_back.sv =====
// Back of the base64 decoder: takes work items from the queue and hands
// out their results one per transfer. Depends on b64d_pkg.
module b64d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  b64d_pkg::work_t     q_item,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic                out_pop,
  output logic                out_empty,
  output b64d_pkg::out_item_t out_item
);

  b64d_pkg::work_t cur_r;
  logic            cur_valid_r, cur_valid_nxt;
  logic [1:0]      idx_r, idx_nxt;
  logic            fire;
  logic            load;

  assign out_empty = !cur_valid_r;

  always_comb begin
    out_item.out_byte    = 8'd0;
    out_item.kind        = b64d_pkg::KIND_END;
    out_item.status      = cur_r.status;
    out_item.last_result = 1'b1;
    if (idx_r < cur_r.nbytes) begin
      case (idx_r)
        2'd0:    out_item.out_byte = cur_r.data[23:16];
        2'd1:    out_item.out_byte = cur_r.data[15:8];
        default: out_item.out_byte = cur_r.data[7:0];
      endcase
      out_item.kind        = b64d_pkg::KIND_DATA;
      out_item.status      = b64d_pkg::STATUS_OK;
      out_item.last_result = (idx_r == cur_r.nbytes - 2'd1) && !cur_r.is_end;
    end
  end

  assign fire  = out_pop && cur_valid_r;
  // refill when idle or when the last result of this item leaves
  assign load  = !cur_valid_r || (fire && out_item.last_result);
  assign q_pop = load && !q_empty;

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (load) begin
      cur_valid_nxt = !q_empty;
      idx_nxt       = 2'd0;
    end else if (fire) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

`ifndef SYNTH
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> ({1'b0, idx_r} < ({1'b0, cur_r.nbytes} + {2'b00, cur_r.is_end})))
    else $error("result index beyond item result count");

  a_item_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (cur_r.nbytes != 2'd0 || cur_r.is_end))
    else $error("work item with no results");

  a_idle_refill: assert property (@(posedge clk) disable iff (!rst_n)
    (!cur_valid_r && !q_empty) |=> cur_valid_r)
    else $error("queued item not picked up while idle");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !out_item.last_result) |=> (cur_valid_r && idx_r == $past(idx_r) + 2'd1))
    else $error("result index did not advance on transfer");
`endif

endmodule
